// ===== rtl/peer_table_with_aging_macros.svh =====
// ----------------------------------------------------------------------------
// peer table assertion macros
// shared property wrappers for the peer table rtl
// ----------------------------------------------------------------------------
`ifndef PEER_TABLE_WITH_AGING_MACROS_SVH
`define PEER_TABLE_WITH_AGING_MACROS_SVH

// checked on every rising edge of aclk outside reset
`define PTAG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every rising edge of aclk, reset included
`define PTAG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/ptag_pkg.sv =====
// ----------------------------------------------------------------------------
// ptag_pkg
// field widths, operation codes and status codes of the peer table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptag_pkg;

    localparam int OP_W       = 2;
    localparam int IP_W       = 32;
    localparam int IDX_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 4;
    localparam int LIFE_W     = 8;
    localparam int ENTRY_W    = IP_W + LIFE_W;

    // stream payload: fields packed from bit 0 up, padded to whole bytes
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - (STATUS_W + COUNT_W + IP_W + LIFE_W);

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd3;

    typedef enum logic [OP_W-1:0] {
        OP_REFRESH = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_AGE     = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_REFRESHED = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_DONE      = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_READ_OK   = 3'd5,
        STAT_BAD_INDEX = 3'd6
    } status_t;

endpackage

// ===== rtl/ptag_ram.sv =====
// ----------------------------------------------------------------------------
// ptag_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptag_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/peer_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// peer_table_with_aging
// flow: refresh, remove and age walk the table in S_WALK, the single ram read
//   port reading one entry per cycle while kept entries are written back; a
//   read goes through S_READ, a read past the count straight to S_HOLD; the
//   result then waits in S_HOLD until the output register is free
// one request at a time: a new request is taken only after the last result
//   has been moved into the output register
// reset: table empty, lifetime reload 3; no clearing pass, ram is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "peer_table_with_aging_macros.svh"

module peer_table_with_aging #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // lifetime reload register
    input  logic                             cfg_we,
    input  logic [ptag_pkg::LIFE_W-1:0]      cfg_wdata,

    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] operation, [33:2] peer_ip, [37:34] read_index, [39:38] zero
    input  logic [ptag_pkg::S_TDATA_W-1:0]   s_tdata,

    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] status, [6:3] entry_count, [38:7] entry_ip,
    // [46:39] entry_lifetime, [47] zero
    output logic [ptag_pkg::M_TDATA_W-1:0]   m_tdata
);

    import ptag_pkg::*;

    localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    // count never exceeds TABLE_SLOTS - 1, so it fits the address width
    localparam int CNT_W  = ADDR_W;
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,   // waiting for a request transfer
        S_WALK,   // streaming the table through read, modify, write back
        S_READ,   // single entry read in flight
        S_HOLD    // result ready, waiting for the output register
    } state_t;

    // control state
    state_t                 state_reg,    state_next;
    logic [CNT_W-1:0]       count_reg,    count_next;
    logic [ADDR_W-1:0]      rd_ptr_reg,   rd_ptr_next;
    logic [ADDR_W-1:0]      wr_ptr_reg,   wr_ptr_next;
    logic                   pend_reg,     pend_next;
    logic                   found_reg,    found_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [LIFE_W-1:0]      reload_reg,   reload_next;

    // payload
    op_t                    op_reg,       op_next;
    logic [IP_W-1:0]        ip_reg,       ip_next;
    status_t                status_reg,   status_next;
    logic [IP_W-1:0]        res_ip_reg,   res_ip_next;
    logic [LIFE_W-1:0]      res_life_reg, res_life_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg,  m_tdata_next;

    // ram ports
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    // request fields
    op_t                    in_op;
    logic [IP_W-1:0]        in_ip;
    logic [IDX_W-1:0]       in_idx;

    // walk datapath
    logic [IP_W-1:0]        ent_ip;
    logic [LIFE_W-1:0]      ent_life;
    logic [LIFE_W-1:0]      new_life;
    logic                   hit;
    logic                   keep;
    logic                   out_free;

    assign in_op    = op_t'(s_tdata[OP_W-1:0]);
    assign in_ip    = s_tdata[OP_W +: IP_W];
    assign in_idx   = s_tdata[OP_W + IP_W +: IDX_W];

    assign ent_ip   = ram_rdata[LIFE_W +: IP_W];
    assign ent_life = ram_rdata[LIFE_W-1:0];
    assign hit      = (ent_ip == ip_reg);

    // one request at a time; the output register decouples the result side
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // entry keep or drop and its new lifetime, per operation
    always_comb begin
        keep       = 1'b1;
        new_life   = ent_life;
        found_next = found_reg;
        case (op_reg)
            OP_REFRESH: begin
                if (hit && !found_reg) begin
                    new_life   = reload_reg;
                    found_next = 1'b1;
                end
            end
            OP_REMOVE: begin
                // first match is dropped, later entries slide down by one
                if (hit && !found_reg) begin
                    keep       = 1'b0;
                    found_next = 1'b1;
                end
            end
            OP_AGE: begin
                keep     = (ent_life != '0);
                new_life = ent_life - LIFE_W'(1);
            end
            default: begin
                keep = 1'b1;
            end
        endcase
        if (state_reg != S_WALK || !pend_reg) begin
            found_next = found_reg;
        end
        if (state_reg == S_IDLE) begin
            found_next = 1'b0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        pend_next     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        reload_next   = reload_reg;
        op_next       = op_reg;
        ip_next       = ip_reg;
        status_next   = status_reg;
        res_ip_next   = res_ip_reg;
        res_life_next = res_life_reg;
        m_tdata_next  = m_tdata_reg;

        ram_we        = 1'b0;
        ram_waddr     = wr_ptr_reg;
        ram_wdata     = {ent_ip, new_life};
        ram_re        = 1'b0;
        ram_raddr     = rd_ptr_reg;

        if (cfg_we) begin
            reload_next = cfg_wdata;
        end

        // result leaves the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_op;
                    ip_next     = in_ip;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    if (in_op == OP_READ) begin
                        if (CMP_W'(in_idx) < CMP_W'(count_reg)) begin
                            ram_re     = 1'b1;
                            ram_raddr  = ADDR_W'(in_idx);
                            state_next = S_READ;
                        end else begin
                            status_next   = STAT_BAD_INDEX;
                            res_ip_next   = '0;
                            res_life_next = '0;
                            state_next    = S_HOLD;
                        end
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK: begin
                // issue side: one read per cycle up to the held count
                if (rd_ptr_reg != count_reg) begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_ptr_reg;
                    rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                    pend_next   = 1'b1;
                end
                // write-back side: kept entries are packed at the write pointer
                if (pend_reg && keep) begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_ptr_reg;
                    ram_wdata   = {ent_ip, new_life};
                    wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
                end
                // walk drained
                if (rd_ptr_reg == count_reg && !pend_reg) begin
                    res_ip_next   = '0;
                    res_life_next = '0;
                    state_next    = S_HOLD;
                    case (op_reg)
                        OP_REFRESH: begin
                            if (found_reg) begin
                                status_next = STAT_REFRESHED;
                            end else if (count_reg == CNT_W'(TABLE_SLOTS - 1)) begin
                                status_next = STAT_FULL;
                            end else begin
                                // append at the tail
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg;
                                ram_wdata   = {ip_reg, reload_reg};
                                count_next  = count_reg + CNT_W'(1);
                                status_next = STAT_INSERTED;
                            end
                        end
                        OP_REMOVE, OP_AGE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                count_next  = wr_ptr_reg;
                                status_next = STAT_DONE;
                            end
                        end
                        default: begin
                            status_next = STAT_DONE;
                        end
                    endcase
                end
            end

            S_READ: begin
                status_next   = STAT_READ_OK;
                res_ip_next   = ent_ip;
                res_life_next = ent_life;
                state_next    = S_HOLD;
            end

            S_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, res_life_reg, res_ip_reg,
                                     COUNT_W'(count_reg), status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            reload_reg   <= LIFETIME_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            reload_reg   <= reload_next;
        end
        op_reg       <= op_next;
        ip_reg       <= ip_next;
        status_reg   <= status_next;
        res_ip_reg   <= res_ip_next;
        res_life_reg <= res_life_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // address and lifetime of every entry, packed side by side
    ptag_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // write-back never overtakes the read side, so no entry is clobbered early
    `PTAG_ASSERT(a_wr_behind_rd, (state_reg == S_WALK) |-> (wr_ptr_reg <= rd_ptr_reg), "write pointer ahead of read pointer")

    // a request transfer closes the input until its result is issued
    `PTAG_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second request taken while busy")

    // the entry count only moves when a walk finishes
    `PTAG_ASSERT(a_count_at_end, (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_WALK) && (state_reg == S_HOLD), "entry count changed mid walk")

endmodule
